[hdl/count_to_bcd_digit_frames_top_defines.svh]
// Assertion macros for the count to BCD digit frames checker.
// No dependencies; expects signals named clock and reset where used.
`ifndef COUNT_TO_BCD_DIGIT_FRAMES_TOP_DEFINES_SVH
`define COUNT_TO_BCD_DIGIT_FRAMES_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, held off in reset.
`define CBCD_ASSERT_NOW(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock, held off in reset.
`define CBCD_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

[hdl/cbcd_pkg.sv]
// Shared types and constants for the count to BCD digit frames block.
// No dependencies.
`default_nettype none

package cbcd_pkg;

   localparam int CBCD_MAX_DIGITS     = 8;
   localparam int CBCD_DEFAULT_DIGITS = 8;
   localparam int CBCD_COUNT_W        = 32;
   localparam int CBCD_CNT_Q_DEPTH    = 2;
   localparam int CBCD_FRM_Q_DEPTH    = 2;

   localparam logic [3:0]  CBCD_BLANK_CODE = 4'hF;
   localparam logic [7:0]  CBCD_POINT_BIT  = 8'h80;
   localparam logic [2:0]  CBCD_GROUP_SIZE = 3'd3;

   // Divide by ten: q = (x * RECIP) >> SHIFT, exact for every 32-bit x.
   localparam logic [31:0] CBCD_RECIP       = 32'hCCCC_CCCD;
   localparam int          CBCD_RECIP_SHIFT = 35;

   typedef struct packed {
      logic [3:0] digit_register;
      logic [7:0] digit_byte;
      logic       last_frame;
   } cbcd_frame_type;

   typedef struct packed {
      logic full;
      logic empty;
   } cbcd_q_status_type;

   // Separator point on every digit position that is a nonzero multiple of three.
   function automatic logic cbcd_has_point(input logic [2:0] pos);
      return (pos == CBCD_GROUP_SIZE) || (pos == 3'(2 * CBCD_GROUP_SIZE));
   endfunction

endpackage

`default_nettype wire

[hdl/cbcd_fifo.sv]
// Small register-based first-in first-out queue, generic width and depth.
// No dependencies.
`default_nettype none

module cbcd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      rd_data,
   output logic                  full,
   output logic                  empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             do_wr, do_rd;

   assign full    = (fill_ff == CNT_W'(DEPTH));
   assign empty   = (fill_ff == '0);
   assign do_wr   = push && !full;
   assign do_rd   = pop && !empty;
   assign rd_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
         fill_in = fill_ff + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
         fill_in = fill_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

[hdl/cbcd_digit_engine.sv]
// Back end: builds frames from a queued count, one decimal digit per cycle while the frame queue has room.
// Depends on cbcd_pkg.
`default_nettype none

module cbcd_digit_engine #(
   parameter int DIGIT_COUNT = cbcd_pkg::CBCD_DEFAULT_DIGITS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire cbcd_pkg::cbcd_q_status_type   cnt_q,
   input  wire logic [cbcd_pkg::CBCD_COUNT_W-1:0] cnt_data,
   output logic                               cnt_pop,
   input  wire cbcd_pkg::cbcd_q_status_type   frm_q,
   output logic                               frm_push,
   output cbcd_pkg::cbcd_frame_type           frm_data
);

   import cbcd_pkg::*;

   localparam int FRAMES = (DIGIT_COUNT > CBCD_MAX_DIGITS) ? CBCD_MAX_DIGITS : DIGIT_COUNT;
   localparam int POS_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;

   logic                    busy_ff, busy_in;
   logic [CBCD_COUNT_W-1:0] rest_ff, rest_in;
   logic [POS_W-1:0]        pos_ff, pos_in;

   logic [2*CBCD_COUNT_W-1:0] product;
   logic [CBCD_COUNT_W-1:0]   quot;
   logic [CBCD_COUNT_W-1:0]   times_ten;
   logic [3:0]                digit;
   logic                      is_last, blank, emit, done;

   // Reciprocal multiply, then recover the remainder with a shift-add.
   assign product   = {{CBCD_COUNT_W{1'b0}}, rest_ff} * {{CBCD_COUNT_W{1'b0}}, CBCD_RECIP};
   assign quot      = CBCD_COUNT_W'(product >> CBCD_RECIP_SHIFT);
   assign times_ten = (quot << 3) + (quot << 1);
   assign digit     = 4'(rest_ff - times_ten);

   assign is_last = (pos_ff == POS_W'(FRAMES - 1));
   assign blank   = (digit == 4'd0) && (quot == '0) && (pos_ff != '0);
   assign emit    = busy_ff && !frm_q.full;
   assign done    = emit && is_last;
   assign cnt_pop = !cnt_q.empty && (!busy_ff || done);

   always_comb begin
      frm_push                = emit;
      frm_data.digit_register = 4'(pos_ff) + 4'd1;
      frm_data.last_frame     = is_last;
      if (blank) begin
         frm_data.digit_byte = {4'd0, CBCD_BLANK_CODE};
      end else if (cbcd_has_point(3'(pos_ff))) begin
         frm_data.digit_byte = CBCD_POINT_BIT | {4'd0, digit};
      end else begin
         frm_data.digit_byte = {4'd0, digit};
      end
   end

   always_comb begin
      busy_in = busy_ff;
      rest_in = rest_ff;
      pos_in  = pos_ff;
      priority if (cnt_pop) begin
         busy_in = 1'b1;
         rest_in = cnt_data;
         pos_in  = '0;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (emit) begin
         rest_in = quot;
         pos_in  = pos_ff + POS_W'(1);
      end else begin
         // Hold while idle or while the frame queue is full.
         busy_in = busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      rest_ff <= rest_in;
      pos_ff  <= pos_in;
   end

endmodule

`default_nettype wire

[hdl/count_to_bcd_digit_frames_top.sv]
// Top level: count queue, digit engine and frame queue for the BCD display frames.
// Depends on cbcd_pkg, cbcd_fifo and cbcd_digit_engine.
//
//   Channel  Direction  Handshake        Payload
//   req      in         push / full      req_count_value[31:0]
//   rsp      out        pop / empty      rsp_digit_register[3:0], rsp_digit_byte[7:0],
//                                        rsp_last_frame
//
// Each count yields DIGIT_COUNT frames (at most eight), one frame per cycle while the
// frame queue has room; the engine loads the next count as it emits the last frame
// of the one before, and the divide-by-ten step, one digit per cycle, sets the rate.
// A count passes the count queue, the engine registers and the frame queue before it shows.
// Reset is synchronous and empties both queues and idles the engine.
// A stalled rsp side backs up the frame queue, then the engine, then the count
// queue; req_full rises only once two counts wait behind the one in progress.
`default_nettype none

module count_to_bcd_digit_frames_top #(
   parameter int DIGIT_COUNT = cbcd_pkg::CBCD_DEFAULT_DIGITS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   input  wire logic [31:0] req_count_value,
   output logic             req_full,
   input  wire logic        rsp_pop,
   output logic             rsp_empty,
   output logic [3:0]       rsp_digit_register,
   output logic [7:0]       rsp_digit_byte,
   output logic             rsp_last_frame
);

   import cbcd_pkg::*;

   cbcd_q_status_type       cnt_q, frm_q;
   logic [CBCD_COUNT_W-1:0] cnt_data;
   logic                    cnt_pop;
   logic                    frm_push;
   cbcd_frame_type          frm_wr, frm_rd;

   // Front: hold accepted counts until the engine is ready for them.
   cbcd_fifo #(
      .WIDTH (CBCD_COUNT_W),
      .DEPTH (CBCD_CNT_Q_DEPTH)
   ) u_cnt_q (
      .clock   (clock),
      .reset   (reset),
      .push    (req_push),
      .wr_data (req_count_value),
      .pop     (cnt_pop),
      .rd_data (cnt_data),
      .full    (cnt_q.full),
      .empty   (cnt_q.empty)
   );

   // Back: split count into digits, format one frame per cycle unless the frame queue is full.
   cbcd_digit_engine #(
      .DIGIT_COUNT (DIGIT_COUNT)
   ) u_engine (
      .clock    (clock),
      .reset    (reset),
      .cnt_q    (cnt_q),
      .cnt_data (cnt_data),
      .cnt_pop  (cnt_pop),
      .frm_q    (frm_q),
      .frm_push (frm_push),
      .frm_data (frm_wr)
   );

   // Output queue: decouple the engine from a stalling consumer.
   cbcd_fifo #(
      .WIDTH ($bits(cbcd_frame_type)),
      .DEPTH (CBCD_FRM_Q_DEPTH)
   ) u_frm_q (
      .clock   (clock),
      .reset   (reset),
      .push    (frm_push),
      .wr_data (frm_wr),
      .pop     (rsp_pop),
      .rd_data (frm_rd),
      .full    (frm_q.full),
      .empty   (frm_q.empty)
   );

   assign req_full           = cnt_q.full;
   assign rsp_empty          = frm_q.empty;
   assign rsp_digit_register = frm_rd.digit_register;
   assign rsp_digit_byte     = frm_rd.digit_byte;
   assign rsp_last_frame     = frm_rd.last_frame;

endmodule

`default_nettype wire

[hdl/cbcd_checker.sv]
// Port-level checker for the BCD digit frames block, bound to the top level.
// Depends on count_to_bcd_digit_frames_top_defines.svh and cbcd_pkg.
`default_nettype none
`include "count_to_bcd_digit_frames_top_defines.svh"

module cbcd_checker #(
   parameter int DIGIT_COUNT = cbcd_pkg::CBCD_DEFAULT_DIGITS
) (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_pop,
   input wire logic        rsp_empty,
   input wire logic [3:0]  rsp_digit_register,
   input wire logic [7:0]  rsp_digit_byte,
   input wire logic        rsp_last_frame
);

   import cbcd_pkg::*;

   localparam int FRAMES = (DIGIT_COUNT > CBCD_MAX_DIGITS) ? CBCD_MAX_DIGITS : DIGIT_COUNT;
   localparam logic [3:0] LAST_REG = 4'(FRAMES);

   logic       shown, last_shown, on_last_reg, reg_ok;
   logic       pop_mid, pop_last, run_start, reg_stepped;
   logic       blank_shown, blank_clean;
   logic [3:0] reg_next_ff, reg_next_in;

   assign shown       = !rsp_empty;
   assign last_shown  = shown && rsp_last_frame;
   assign on_last_reg = (rsp_digit_register == LAST_REG);
   assign reg_ok      = (rsp_digit_register >= 4'd1) && (rsp_digit_register <= LAST_REG);
   assign pop_mid     = shown && rsp_pop && !rsp_last_frame;
   assign pop_last    = shown && rsp_pop && rsp_last_frame;
   assign run_start   = rsp_empty || (rsp_digit_register == 4'd1);
   assign reg_next_in = rsp_digit_register + 4'd1;
   assign reg_stepped = rsp_empty || (rsp_digit_register == reg_next_ff);
   assign blank_shown = shown && (rsp_digit_byte[3:0] == CBCD_BLANK_CODE);
   assign blank_clean = (rsp_digit_byte[7:4] == 4'd0);

   // Keep the register that follows the one on the ports now.
   always_ff @(posedge clock) begin
      reg_next_ff <= reg_next_in;
   end

   `CBCD_ASSERT_NOW(a_last_on_final_reg, last_shown, on_last_reg, "last frame off final digit")
   `CBCD_ASSERT_NOW(a_reg_in_range, shown, reg_ok, "digit register out of range")
   `CBCD_ASSERT_NOW(a_blank_no_point, blank_shown, blank_clean, "blank digit has extra bits")
   `CBCD_ASSERT_NEXT(a_reg_advance, pop_mid, reg_stepped, "digit register did not advance")
   `CBCD_ASSERT_NEXT(a_first_after_last, pop_last, run_start, "new run not at digit one")

endmodule

bind count_to_bcd_digit_frames_top cbcd_checker #(
   .DIGIT_COUNT (DIGIT_COUNT)
) u_cbcd_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_pop            (rsp_pop),
   .rsp_empty          (rsp_empty),
   .rsp_digit_register (rsp_digit_register),
   .rsp_digit_byte     (rsp_digit_byte),
   .rsp_last_frame     (rsp_last_frame)
);

`default_nettype wire
